/* rtl/core/tgba_pkg.sv */
// Package for the two-group batch arbiter.
// Holds transaction types, operation codes, holder and status codes.
// No dependencies.
package tgba_pkg;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_DEPART = 1'b1;

    localparam logic [1:0] HOLD_NONE = 2'd0;
    localparam logic [1:0] HOLD_G0   = 2'd1;
    localparam logic [1:0] HOLD_G1   = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_DEPART = 2'd1;
    localparam logic [1:0] ST_WAIT_FULL  = 2'd2;

    localparam logic [7:0] BATCH_LIMIT_RST = 8'd4;

    typedef struct packed {
        logic cmd;
        logic group;
    } event_t;

    typedef struct packed {
        logic       grant_group;
        logic [7:0] grant_count;
        logic [7:0] waiting_group0;
        logic [7:0] waiting_group1;
        logic [7:0] inside_now;
        logic [1:0] holder;
        logic [1:0] status;
    } result_t;

    // Classified operation passed from front to back
    typedef struct packed {
        logic is_depart;
        logic grp;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } op_queue_t;

endpackage

/* rtl/core/tgba_front.sv */
// Front part of the two-group batch arbiter: accepts and classifies events.
// Holds a two-entry queue of operations towards the back part.
// Depends on tgba_pkg.
module tgba_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  tgba_pkg::event_t     event_item,
    output tgba_pkg::op_queue_t  head,
    input  logic                 take
);

    tgba_pkg::op_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          do_push;
    logic          do_take;
    tgba_pkg::op_t new_op;

    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign do_take = take && (count_reg != 2'd0);

    assign new_op.is_depart = (event_item.cmd == tgba_pkg::CMD_DEPART);
    assign new_op.grp       = event_item.group;

    assign head.valid = (count_reg != 2'd0);
    assign head.op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_take)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= new_op;
        end
    end

endmodule

/* rtl/core/tgba_back.sv */
// Back part of the two-group batch arbiter: carries out operations.
// Holds the arbitration state, the batch limit register and the result queue.
// Depends on tgba_pkg.
module tgba_back
#(
    parameter int MAX_CLIENTS = 255
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tgba_pkg::op_queue_t  head,
    output logic                 take,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data,
    output logic                 empty,
    input  logic                 pop,
    output tgba_pkg::result_t    result_item
);

    localparam logic [7:0] CAP = (MAX_CLIENTS < 255) ? 8'(MAX_CLIENTS) : 8'd255;

    logic [7:0] limit_reg;
    logic [7:0] wait0_reg;
    logic [7:0] wait0_next;
    logic [7:0] wait1_reg;
    logic [7:0] wait1_next;
    logic [7:0] inside_reg;
    logic [7:0] inside_next;
    logic [1:0] owner_reg;
    logic [1:0] owner_next;
    logic [7:0] batch_reg;
    logic [7:0] batch_next;

    tgba_pkg::result_t res;
    tgba_pkg::result_t slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              do_pop;

    assign cfg_ready = 1'b1;
    assign take      = head.valid && (count_reg != 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign do_pop    = pop && !empty;
    assign result_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        logic [7:0] limit;
        logic [7:0] w_g;
        logic [7:0] w_o;
        logic [7:0] w_g_new;
        logic [7:0] w_o_new;
        logic [1:0] own_g;
        logic [1:0] own_o;
        logic [7:0] n_lim;
        logic [7:0] n_sel;
        logic [7:0] n_fin;
        logic [7:0] n_own;
        logic [7:0] ins_dec;
        logic       blocked;
        logic       grant_grp;
        logic [7:0] grant_cnt;
        logic [1:0] status;

        limit   = (limit_reg == 8'd0) ? 8'd1 : limit_reg;
        w_g     = head.op.grp ? wait1_reg : wait0_reg;
        w_o     = head.op.grp ? wait0_reg : wait1_reg;
        own_g   = head.op.grp ? tgba_pkg::HOLD_G1 : tgba_pkg::HOLD_G0;
        own_o   = head.op.grp ? tgba_pkg::HOLD_G0 : tgba_pkg::HOLD_G1;
        n_lim   = (w_o < limit) ? w_o : limit;
        n_sel   = (w_g != 8'd0) ? n_lim : w_o;
        n_fin   = (n_sel < CAP) ? n_sel : CAP;
        n_own   = (w_g < CAP) ? w_g : CAP;
        ins_dec = inside_reg - 8'd1;
        blocked = (owner_reg == own_o) || (batch_reg >= limit) || (inside_reg >= CAP);

        w_g_new     = w_g;
        w_o_new     = w_o;
        inside_next = inside_reg;
        owner_next  = owner_reg;
        batch_next  = batch_reg;
        grant_grp   = 1'b0;
        grant_cnt   = 8'd0;
        status      = tgba_pkg::ST_OK;

        if (!head.op.is_depart)
        begin
            if (blocked)
            begin
                if (w_g >= CAP)
                begin
                    status = tgba_pkg::ST_WAIT_FULL;
                end
                else
                begin
                    w_g_new = w_g + 8'd1;
                end
            end
            else
            begin
                owner_next  = own_g;
                inside_next = inside_reg + 8'd1;
                if ((w_o != 8'd0) && (batch_reg != 8'd255))
                begin
                    batch_next = batch_reg + 8'd1;
                end
                grant_grp = head.op.grp;
                grant_cnt = 8'd1;
            end
        end
        else
        begin
            if ((inside_reg == 8'd0) || (owner_reg != own_g))
            begin
                status = tgba_pkg::ST_BAD_DEPART;
            end
            else
            begin
                inside_next = ins_dec;
                if (ins_dec == 8'd0)
                begin
                    if (w_o != 8'd0)
                    begin
                        batch_next  = (w_g != 8'd0) ? n_fin : 8'd0;
                        w_o_new     = w_o - n_fin;
                        inside_next = n_fin;
                        owner_next  = own_o;
                        grant_grp   = ~head.op.grp;
                        grant_cnt   = n_fin;
                    end
                    else if (w_g != 8'd0)
                    begin
                        batch_next  = 8'd0;
                        w_g_new     = w_g - n_own;
                        inside_next = n_own;
                        owner_next  = own_g;
                        grant_grp   = head.op.grp;
                        grant_cnt   = n_own;
                    end
                    else
                    begin
                        batch_next = 8'd0;
                        owner_next = tgba_pkg::HOLD_NONE;
                    end
                end
            end
        end

        wait0_next = head.op.grp ? w_o_new : w_g_new;
        wait1_next = head.op.grp ? w_g_new : w_o_new;

        res.grant_group    = (grant_cnt != 8'd0) ? grant_grp : 1'b0;
        res.grant_count    = grant_cnt;
        res.waiting_group0 = wait0_next;
        res.waiting_group1 = wait1_next;
        res.inside_now     = inside_next;
        res.holder         = owner_next;
        res.status         = status;
    end

    always_comb
    begin
        count_next = count_reg;
        if (take && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!take && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= tgba_pkg::BATCH_LIMIT_RST;
            wait0_reg  <= 8'd0;
            wait1_reg  <= 8'd0;
            inside_reg <= 8'd0;
            owner_reg  <= tgba_pkg::HOLD_NONE;
            batch_reg  <= 8'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (take)
            begin
                wait0_reg  <= wait0_next;
                wait1_reg  <= wait1_next;
                inside_reg <= inside_next;
                owner_reg  <= owner_next;
                batch_reg  <= batch_next;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            slot_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

/* rtl/core/two_group_batch_arbiter_top.sv */
// Top level of the two-group batch arbiter: front queue, back execution unit.
// Depends on tgba_pkg, tgba_front and tgba_back.
// A transaction is held in the front queue; its result is then registered in the result queue.
// Throughput: one transaction per cycle while the result queue is not full, set by the state update on each take.
// Reset: queues empty, counters zero, resource idle, batch limit 4.
module two_group_batch_arbiter_top
#(
    parameter int MAX_CLIENTS = 255
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  tgba_pkg::event_t   event_item,
    output logic               empty,
    input  logic               pop,
    output tgba_pkg::result_t  result_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);

    tgba_pkg::op_queue_t head;
    logic                take;

    tgba_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .event_item (event_item),
        .head       (head),
        .take       (take)
    );

    tgba_back
    #(
        .MAX_CLIENTS (MAX_CLIENTS)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .take        (take),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .empty       (empty),
        .pop         (pop),
        .result_item (result_item)
    );

endmodule
